// ===== rtl/core/rmc_pkg.sv =====
// Shared types, character codes and helpers for the RMC time/date extractor.
// Depends on nothing; rmc_core, rmc_out_stage and the top level refer to it by scoped names.
`timescale 1ns / 1ps

package rmc_pkg;

	// Status codes of a result
	localparam logic [2:0] ST_OK      = 3'd0;
	localparam logic [2:0] ST_NOHDR   = 3'd1;
	localparam logic [2:0] ST_INVALID = 3'd2;
	localparam logic [2:0] ST_BADTIME = 3'd3;
	localparam logic [2:0] ST_BADDATE = 3'd4;

	// Characters with a meaning in the sentence
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_POINT  = 8'h2E;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_VALID  = 8'h41;

	// Header length and field numbers (commas counted from the header)
	localparam logic [2:0] HDR_LEN    = 3'd6;
	localparam logic [3:0] FLD_TIME   = 4'd1;
	localparam logic [3:0] FLD_STATUS = 4'd2;
	localparam logic [3:0] FLD_DATE   = 4'd9;
	localparam logic [3:0] FLD_MAX    = 4'd15;
	localparam logic [2:0] POS_DIGITS = 3'd6;
	localparam logic [2:0] POS_MAX    = 3'd7;

	// One result item
	typedef struct packed {
		logic [6:0] hour;
		logic [6:0] minute;
		logic [6:0] second;
		logic [6:0] day;
		logic [6:0] month;
		logic [6:0] year;
		logic [2:0] status;
	} rmc_result_t;

	// Expected header character at a given match position
	function automatic logic [7:0] hdr_char(input logic [2:0] pos);
		logic [7:0] c;
		unique case (pos)
			3'd0:    c = 8'h24; // $
			3'd1:    c = 8'h47; // G
			3'd2:    c = 8'h50; // P
			3'd3:    c = 8'h52; // R
			3'd4:    c = 8'h4D; // M
			3'd5:    c = 8'h43; // C
			default: c = 8'h00;
		endcase
		return c;
	endfunction

	// Two BCD digits to a binary value, hi*10 + lo
	function automatic logic [6:0] pair_val(input logic [3:0] hi, input logic [3:0] lo);
		return {hi, 3'b000} + 7'({hi, 1'b0}) + 7'(lo);
	endfunction

endpackage

// ===== rtl/core/rmc_if.sv =====
// Valid/ready channel interfaces: one for incoming characters, one for results.
// Depends on no other file.
`timescale 1ns / 1ps

interface rmc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       last;

	modport source (output valid, output ch, output last, input ready);
	modport sink   (input valid, input ch, input last, output ready);
endinterface

interface rmc_out_if;
	logic       valid;
	logic       ready;
	logic [6:0] hour;
	logic [6:0] minute;
	logic [6:0] second;
	logic [6:0] day;
	logic [6:0] month;
	logic [6:0] year;
	logic [2:0] status;

	modport source (output valid, output hour, output minute, output second,
		output day, output month, output year, output status, input ready);
	modport sink   (input valid, input hour, input minute, input second,
		input day, input month, input year, input status, output ready);
endinterface

// ===== rtl/core/rmc_core.sv =====
// Per-character sentence state and result formation for the RMC extractor.
// Depends on rmc_pkg for character codes, status codes and the result type.
`timescale 1ns / 1ps

module rmc_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  logic [7:0]           ch,
	input  logic                 last,
	output logic                 fire,
	output rmc_pkg::rmc_result_t res
);

	typedef struct packed {
		logic [2:0]      hpos;
		logic            hok;
		logic [3:0]      fidx;
		logic [2:0]      cpos;
		logic            point;
		logic [0:5][3:0] tdig;
		logic [0:5][3:0] ddig;
		logic [2:0]      err;
	} rmc_state_t;

	localparam rmc_state_t STATE_CLR = '0;

	rmc_state_t st_q;
	rmc_state_t upd;
	rmc_state_t nxt;
	logic [2:0] fin_err;
	logic       is_dig;

	// Keep the most urgent error: lowest nonzero code
	function automatic logic [2:0] raise(input logic [2:0] err, input logic [2:0] code);
		return (err == rmc_pkg::ST_OK || code < err) ? code : err;
	endfunction

	// Check the field that a comma or the sentence end closes
	function automatic logic [2:0] close_fld(input logic [2:0] err, input logic [3:0] fidx,
		input logic [2:0] cpos);
		logic [2:0] e;
		e = err;
		if (fidx == rmc_pkg::FLD_TIME && cpos != rmc_pkg::POS_DIGITS)
			e = raise(e, rmc_pkg::ST_BADTIME);
		if (fidx == rmc_pkg::FLD_STATUS && cpos == 3'd0)
			e = raise(e, rmc_pkg::ST_INVALID);
		if (fidx == rmc_pkg::FLD_DATE && cpos != rmc_pkg::POS_DIGITS)
			e = raise(e, rmc_pkg::ST_BADDATE);
		return e;
	endfunction

	assign is_dig = (ch >= rmc_pkg::CH_ZERO) && (ch <= rmc_pkg::CH_NINE);

	// Apply one character to the sentence state
	always_comb begin
		upd = st_q;
		if (ch == rmc_pkg::CH_DOLLAR) begin
			upd      = STATE_CLR;
			upd.hpos = 3'd1;
		end else if (!st_q.hok) begin
			if (st_q.hpos >= 3'd1 && st_q.hpos < rmc_pkg::HDR_LEN &&
				ch == rmc_pkg::hdr_char(st_q.hpos)) begin
				upd.hpos = st_q.hpos + 3'd1;
				upd.hok  = (st_q.hpos + 3'd1 == rmc_pkg::HDR_LEN);
			end else begin
				upd.hpos = 3'd0;
			end
		end else if (ch == rmc_pkg::CH_COMMA) begin
			upd.err   = close_fld(st_q.err, st_q.fidx, st_q.cpos);
			upd.fidx  = (st_q.fidx != rmc_pkg::FLD_MAX) ? st_q.fidx + 4'd1 : st_q.fidx;
			upd.cpos  = 3'd0;
			upd.point = 1'b0;
		end else if (st_q.fidx == rmc_pkg::FLD_TIME) begin
			if (!st_q.point) begin
				if (ch == rmc_pkg::CH_POINT) begin
					upd.point = 1'b1;
				end else begin
					if (!is_dig)
						upd.err = raise(st_q.err, rmc_pkg::ST_BADTIME);
					else if (st_q.cpos < rmc_pkg::POS_DIGITS)
						upd.tdig[st_q.cpos] = ch[3:0];
					if (st_q.cpos != rmc_pkg::POS_MAX)
						upd.cpos = st_q.cpos + 3'd1;
				end
			end
		end else if (st_q.fidx == rmc_pkg::FLD_STATUS) begin
			if (st_q.cpos == 3'd0 && ch != rmc_pkg::CH_VALID)
				upd.err = raise(st_q.err, rmc_pkg::ST_INVALID);
			if (st_q.cpos != rmc_pkg::POS_MAX)
				upd.cpos = st_q.cpos + 3'd1;
		end else if (st_q.fidx == rmc_pkg::FLD_DATE) begin
			if (!is_dig)
				upd.err = raise(st_q.err, rmc_pkg::ST_BADDATE);
			else if (st_q.cpos < rmc_pkg::POS_DIGITS)
				upd.ddig[st_q.cpos] = ch[3:0];
			if (st_q.cpos != rmc_pkg::POS_MAX)
				upd.cpos = st_q.cpos + 3'd1;
		end
	end

	// Close the sentence on its last character
	always_comb begin
		fin_err = close_fld(upd.err, upd.fidx, upd.cpos);
		if (upd.fidx < rmc_pkg::FLD_TIME)
			fin_err = raise(fin_err, rmc_pkg::ST_BADTIME);
		if (upd.fidx < rmc_pkg::FLD_STATUS)
			fin_err = raise(fin_err, rmc_pkg::ST_INVALID);
		if (upd.fidx < rmc_pkg::FLD_DATE)
			fin_err = raise(fin_err, rmc_pkg::ST_BADDATE);
		if (!upd.hok)
			fin_err = rmc_pkg::ST_NOHDR;

		res = '0;
		res.status = fin_err;
		if (fin_err == rmc_pkg::ST_OK) begin
			res.hour   = rmc_pkg::pair_val(upd.tdig[0], upd.tdig[1]);
			res.minute = rmc_pkg::pair_val(upd.tdig[2], upd.tdig[3]);
			res.second = rmc_pkg::pair_val(upd.tdig[4], upd.tdig[5]);
			res.day    = rmc_pkg::pair_val(upd.ddig[0], upd.ddig[1]);
			res.month  = rmc_pkg::pair_val(upd.ddig[2], upd.ddig[3]);
			res.year   = rmc_pkg::pair_val(upd.ddig[4], upd.ddig[5]);
		end
	end

	assign fire = step && last;
	assign nxt  = last ? STATE_CLR : upd;

	// Advance the state on each processed character
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= STATE_CLR;
		end else if (step) begin
			st_q <= nxt;
		end
	end

endmodule

// ===== rtl/core/rmc_out_stage.sv =====
// Result register driving the output channel of the RMC extractor.
// Depends on rmc_pkg for the result type and rmc_if for the channel.
`timescale 1ns / 1ps

module rmc_out_stage (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  rmc_pkg::rmc_result_t res,
	output logic                 free,
	rmc_out_if.source            fix
);

	logic                 valid_q;
	rmc_pkg::rmc_result_t res_q;

	assign free = !valid_q || fix.ready;

	// Hold the result until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (fix.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign fix.valid  = valid_q;
	assign fix.hour   = res_q.hour;
	assign fix.minute = res_q.minute;
	assign fix.second = res_q.second;
	assign fix.day    = res_q.day;
	assign fix.month  = res_q.month;
	assign fix.year   = res_q.year;
	assign fix.status = res_q.status;

endmodule

// ===== rtl/core/nmea_rmc_time_date_extractor.sv =====
// Top level of the RMC time/date extractor: input register, parser, result register.
// Depends on rmc_pkg, rmc_if, rmc_core and rmc_out_stage.
//
// Usage:
//   chars takes one sentence character per request (ch, last). Requests
//   with last = 0 produce nothing; a request with last = 1 closes the
//   sentence and produces one request on fix with hour, minute, second,
//   day, month, year and status (0 ok, 1 no header, 2 data invalid,
//   3 bad time, 4 bad date; values are zero when status is nonzero).
//   Throughput is one character per cycle while no character with last
//   waits for the result register. A character is captured in the input
//   register at acceptance and then applied to the parser state; when the
//   last character is applied, the result register takes the result and
//   drives fix, with the sentence state updated once per applied character.
//   When fix stalls, the result register holds its request; characters
//   without last keep flowing, and a character with last waits in the
//   input register until the result register frees, which then stalls
//   chars. Reset clears the sentence state and both valid flags.
`timescale 1ns / 1ps

module nmea_rmc_time_date_extractor (
	input  logic      clk,
	input  logic      arst_n,
	rmc_in_if.sink    chars,
	rmc_out_if.source fix
);

	logic                 valid_s1;
	logic [7:0]           ch_s1;
	logic                 last_s1;
	logic                 out_free;
	logic                 go;
	logic                 fire;
	rmc_pkg::rmc_result_t res;

	// Process the held character unless it closes a sentence into a full output
	assign go          = valid_s1 && (!last_s1 || out_free);
	assign chars.ready = !valid_s1 || go;

	// Capture the incoming request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			ch_s1   <= chars.ch;
			last_s1 <= chars.last;
		end
	end

	rmc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (go),
		.ch     (ch_s1),
		.last   (last_s1),
		.fire   (fire),
		.res    (res)
	);

	rmc_out_stage u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (fire),
		.res    (res),
		.free   (out_free),
		.fix    (fix)
	);

endmodule
